// File: sv/cle_pkg.sv
`default_nettype none

package cle_pkg;

  // Field widths of the command and result transfers
  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 10;
  localparam int OUT_CNT_W = 11;
  localparam int STAT_W   = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_in;
    logic [IDX_W-1:0]  read_index;
  } cle_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]    char_out;
    logic [OUT_CNT_W-1:0] text_length;
    logic [OUT_CNT_W-1:0] cursor_pos;
    logic [STAT_W-1:0]    status;
  } cle_out_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_MVL,
    CELL_MVR,
    CELL_DEL
  } cle_cell_op_t;

  typedef struct packed {
    cle_cell_op_t      op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  rd_idx;
  } cle_cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/cle_cell.sv
`default_nettype none

// One text position. flag_r marks a position left of the cursor; the
// flags form a thermometer code along the chain. Edits move bytes and
// flags one cell per cycle; the read path passes the selected byte
// toward cell 0, one cell per cycle.
module cle_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cle_pkg::cle_cell_ctrl_t        ctrl,
  input  wire logic [cle_pkg::CHAR_W-1:0]     data_lo,
  input  wire logic                           flag_lo,
  input  wire logic [cle_pkg::CHAR_W-1:0]     data_hi,
  input  wire logic                           flag_hi,
  input  wire logic [cle_pkg::CHAR_W-1:0]     res_hi,
  output      logic [cle_pkg::CHAR_W-1:0]     data_o,
  output      logic                           flag_o,
  output      logic [cle_pkg::CHAR_W-1:0]     res_o
);

  localparam bit REACH = (INDEX < (2 ** cle_pkg::IDX_W));

  logic [cle_pkg::CHAR_W-1:0] data_r, data_nxt;
  logic                       flag_r, flag_nxt;
  logic [cle_pkg::CHAR_W-1:0] res_r, res_nxt;
  logic                       hit;

  assign hit = REACH && (ctrl.rd_idx == cle_pkg::IDX_W'(INDEX));

  // Shift byte and cursor flag according to the broadcast operation
  always_comb begin
    data_nxt = data_r;
    flag_nxt = flag_r;
    case (ctrl.op)
      cle_pkg::CELL_HOLD: begin
      end
      cle_pkg::CELL_INS: begin
        flag_nxt = flag_lo;
        if (!flag_r) begin
          data_nxt = flag_lo ? ctrl.ch : data_lo;
        end
      end
      cle_pkg::CELL_MVL: begin
        flag_nxt = flag_hi;
      end
      cle_pkg::CELL_MVR: begin
        flag_nxt = flag_lo;
      end
      cle_pkg::CELL_DEL: begin
        flag_nxt = flag_hi;
        if (!flag_hi) begin
          data_nxt = data_hi;
        end
      end
      default: begin
      end
    endcase
  end

  // Inject own byte on a hit, else pass the upper neighbor's byte down
  assign res_nxt = hit ? data_r : res_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
    data_r <= data_nxt;
    res_r  <= res_nxt;
  end

  assign data_o = data_r;
  assign flag_o = flag_r;
  assign res_o  = res_r;

endmodule

`default_nettype wire

// File: sv/cursor_line_edit_buffer_core.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   cle_pkg::cle_in_t  in_data
// out_      output     out_valid / out_stall cle_pkg::cle_out_t out_data
//
// Insert, cursor moves, delete and every rejected command pass straight to
// the result stage: a new command can be taken each cycle while the result
// stage drains. A read in range walks the byte from its cell to cell 0
// through the read path of the cell chain, one cell per cycle.
// Synchronous active-low reset empties the text and puts the cursor at 0.
// A stalled output holds one result in the output register and one in the
// result stage; input is stalled while both are held or a read is running.
module cursor_line_edit_buffer_core #(
  parameter int DEPTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire cle_pkg::cle_in_t  in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      cle_pkg::cle_out_t out_data
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int RCNT_W = cle_pkg::IDX_W + 1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            left_cnt_r, left_cnt_nxt;
  logic [CNT_W-1:0]            len_r, len_nxt;
  logic [RCNT_W-1:0]           rd_cnt_r, rd_cnt_nxt;
  logic [cle_pkg::IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                        res_valid_r, res_valid_nxt;
  cle_pkg::cle_out_t           res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  cle_pkg::cle_out_t           out_r, out_nxt;

  cle_pkg::cle_cell_ctrl_t     ctrl;
  logic                        accept;
  logic                        out_load;
  logic                        res_free;

  logic [cle_pkg::CHAR_W-1:0]  cell_data [DEPTH];
  logic                        cell_flag [DEPTH];
  logic [cle_pkg::CHAR_W-1:0]  cell_res  [DEPTH];

  // Output and result stage handshake
  assign out_load = res_valid_r && (!out_valid_r || !out_stall);
  assign res_free = !res_valid_r || out_load;
  assign in_stall = (state_r != ST_IDLE) || !res_free;
  assign accept   = in_valid && !in_stall;

  // Decode the command, update counts and drive the cell chain
  always_comb begin
    state_nxt     = state_r;
    left_cnt_nxt  = left_cnt_r;
    len_nxt       = len_r;
    rd_cnt_nxt    = rd_cnt_r;
    rd_idx_nxt    = rd_idx_r;
    res_valid_nxt = res_valid_r && !out_load;
    res_nxt       = res_r;
    ctrl.op       = cle_pkg::CELL_HOLD;
    ctrl.ch       = in_data.char_in;
    ctrl.rd_idx   = rd_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt.char_out = '0;
          res_nxt.status   = cle_pkg::STAT_DONE;
          res_valid_nxt    = 1'b1;
          case (in_data.command)
            cle_pkg::CMD_INSERT: begin
              if (len_r == CNT_W'(DEPTH)) begin
                res_nxt.status = cle_pkg::STAT_FULL;
              end else begin
                ctrl.op      = cle_pkg::CELL_INS;
                left_cnt_nxt = left_cnt_r + 1'b1;
                len_nxt      = len_r + 1'b1;
              end
            end
            cle_pkg::CMD_LEFT: begin
              if (left_cnt_r == '0) begin
                res_nxt.status = cle_pkg::STAT_BOUND;
              end else begin
                ctrl.op      = cle_pkg::CELL_MVL;
                left_cnt_nxt = left_cnt_r - 1'b1;
              end
            end
            cle_pkg::CMD_RIGHT: begin
              if (left_cnt_r == len_r) begin
                res_nxt.status = cle_pkg::STAT_BOUND;
              end else begin
                ctrl.op      = cle_pkg::CELL_MVR;
                left_cnt_nxt = left_cnt_r + 1'b1;
              end
            end
            cle_pkg::CMD_DELETE: begin
              if (left_cnt_r == '0) begin
                res_nxt.status = cle_pkg::STAT_BOUND;
              end else begin
                ctrl.op      = cle_pkg::CELL_DEL;
                left_cnt_nxt = left_cnt_r - 1'b1;
                len_nxt      = len_r - 1'b1;
              end
            end
            cle_pkg::CMD_READ: begin
              if (32'(in_data.read_index) >= 32'(len_r)) begin
                res_nxt.status = cle_pkg::STAT_RANGE;
              end else begin
                // start the walk toward cell 0; result comes later
                res_valid_nxt = res_valid_r && !out_load;
                rd_idx_nxt    = in_data.read_index;
                rd_cnt_nxt    = RCNT_W'(in_data.read_index) + 1'b1;
                state_nxt     = ST_READ;
              end
            end
            default: begin
              res_nxt.status = cle_pkg::STAT_BOUND;
            end
          endcase
          res_nxt.text_length = cle_pkg::OUT_CNT_W'(len_nxt);
          res_nxt.cursor_pos  = cle_pkg::OUT_CNT_W'(left_cnt_nxt);
        end
      end
      ST_READ: begin
        if (rd_cnt_r != '0) begin
          rd_cnt_nxt = rd_cnt_r - 1'b1;
        end else if (res_free) begin
          // byte has reached cell 0: capture it
          res_nxt.char_out    = cell_res[0];
          res_nxt.status      = cle_pkg::STAT_DONE;
          res_nxt.text_length = cle_pkg::OUT_CNT_W'(len_r);
          res_nxt.cursor_pos  = cle_pkg::OUT_CNT_W'(left_cnt_r);
          res_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance the output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  // Hold state, counts and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      left_cnt_r  <= '0;
      len_r       <= '0;
      rd_cnt_r    <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_cnt_r  <= left_cnt_nxt;
      len_r       <= len_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r <= rd_idx_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Chain of text cells, position 0 at the low end
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [cle_pkg::CHAR_W-1:0] data_lo;
    logic                       flag_lo;
    logic [cle_pkg::CHAR_W-1:0] data_hi;
    logic                       flag_hi;
    logic [cle_pkg::CHAR_W-1:0] res_hi;

    if (g == 0) begin : g_lo_end
      assign data_lo = '0;
      assign flag_lo = 1'b1;
    end else begin : g_lo_link
      assign data_lo = cell_data[g-1];
      assign flag_lo = cell_flag[g-1];
    end

    if (g == DEPTH - 1) begin : g_hi_end
      assign data_hi = '0;
      assign flag_hi = 1'b0;
      assign res_hi  = '0;
    end else begin : g_hi_link
      assign data_hi = cell_data[g+1];
      assign flag_hi = cell_flag[g+1];
      assign res_hi  = cell_res[g+1];
    end

    cle_cell #(
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .data_lo (data_lo),
      .flag_lo (flag_lo),
      .data_hi (data_hi),
      .flag_hi (flag_hi),
      .res_hi  (res_hi),
      .data_o  (cell_data[g]),
      .flag_o  (cell_flag[g]),
      .res_o   (cell_res[g])
    );
  end

endmodule

`default_nettype wire
